>>> rtl/tkb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt drive package
// Shared constants, codes and helper functions for the tilt estimator.
// ----------------------------------------------------------------------------
package tkb_pkg;

  localparam int unsigned CORDIC_STEPS = 20;

  localparam logic signed [24:0] NINETY_Q16 = 25'sd5898240;
  localparam logic signed [47:0] EST_MAX    = 48'sd16777215;
  localparam logic signed [47:0] EST_MIN    = -48'sd16777216;

  localparam logic [23:0] PROCESS_NOISE_RST  = 24'd58982;
  localparam logic [23:0] MEASURE_NOISE_RST  = 24'd655;
  localparam logic [23:0] STEP_TIME_RST      = 24'd64525;
  localparam logic [6:0]  TILT_THRESHOLD_RST = 7'd2;
  localparam logic [15:0] PWM_PERIOD_RST     = 16'd20000;
  localparam logic [31:0] ERROR_COV_RST      = 32'd262144;

  localparam logic [6:0]  DUTY_BELOW = 7'd115;
  localparam logic [6:0]  DUTY_BAND  = 7'd75;
  localparam logic [6:0]  DUTY_ABOVE = 7'd35;
  localparam logic [13:0] RECIP_1000 = 14'd8389;
  localparam logic [9:0]  THOUSAND   = 10'd1000;

  typedef enum logic [2:0] {
    REG_PROCESS_NOISE  = 3'd0,
    REG_MEASURE_NOISE  = 3'd1,
    REG_STEP_TIME      = 3'd2,
    REG_TILT_THRESHOLD = 3'd3,
    REG_PWM_PERIOD     = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_BELOW = 2'd0,
    DIR_BAND  = 2'd1,
    DIR_ABOVE = 2'd2
  } dir_e;

  function automatic logic [31:0] atan_deg(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd754974720;
      5'd1:  r = 32'd445687602;
      5'd2:  r = 32'd235489088;
      5'd3:  r = 32'd119537938;
      5'd4:  r = 32'd60000934;
      5'd5:  r = 32'd30029717;
      5'd6:  r = 32'd15018523;
      5'd7:  r = 32'd7509720;
      5'd8:  r = 32'd3754917;
      5'd9:  r = 32'd1877466;
      5'd10: r = 32'd938734;
      5'd11: r = 32'd469367;
      5'd12: r = 32'd234684;
      5'd13: r = 32'd117342;
      5'd14: r = 32'd58671;
      5'd15: r = 32'd29335;
      5'd16: r = 32'd14668;
      5'd17: r = 32'd7334;
      5'd18: r = 32'd3667;
      5'd19: r = 32'd1833;
      5'd20: r = 32'd917;
      5'd21: r = 32'd458;
      5'd22: r = 32'd229;
      5'd23: r = 32'd115;
      5'd24: r = 32'd57;
      5'd25: r = 32'd29;
      5'd26: r = 32'd14;
      5'd27: r = 32'd7;
      5'd28: r = 32'd4;
      5'd29: r = 32'd2;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [24:0] sat25(input logic signed [47:0] v);
    logic signed [24:0] r;
    if (v > EST_MAX) begin
      r = 25'sd16777215;
    end else if (v < EST_MIN) begin
      r = -25'sd16777216;
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/tilt_kalman_bang_bang_drive.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt Kalman drive
// Tilt estimate from accelerometer and gyro with a three-level PWM drive.
// ----------------------------------------------------------------------------
// The result word follows the 25-step gain divider, which starts in S_SUM, after
// S_PRED, and unless its divisor is zero outlasts the 20-step CORDIC started on
// acceptance; the multiply and PWM steps run after both are done.
// One word is taken at a time; a new word is accepted once the result has
// entered the output register.
// Reset restores the register defaults, a zero estimate and an error of 4.0.
module tilt_kalman_bang_bang_drive
  import tkb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // accel_y [15:0], accel_z [31:16], gyro_rate [53:32]
  input  wire logic [55:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tilt_estimate [24:0], tilt_whole [33:25], drive_dir [35:34], pulse_width [48:36]
  output logic [55:0]      m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [23:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PRED, S_SUM, S_WAIT, S_MUL1, S_MUL2, S_DIR, S_RECIP, S_FIX, S_OUT
  } state_e;

  state_e state_q;

  logic [23:0] process_noise_q, measure_noise_q, step_time_q;
  logic [6:0]  tilt_threshold_q;
  logic [15:0] pwm_period_q;

  logic signed [24:0] angle_est_q;
  logic [31:0]        error_cov_q;

  logic signed [21:0] rate_q;
  logic signed [46:0] gyro_q;
  logic [31:0]        perr_q;
  logic signed [24:0] pred_q;
  logic signed [51:0] corr_prod_q;
  logic [56:0]        cov_prod_q;
  logic signed [8:0]  whole_q;
  logic [1:0]         dir_q;
  logic [22:0]        prod_q;
  logic [13:0]        quot_q;
  logic [12:0]        pulse_q;
  logic               m_valid_q;
  logic [55:0]        m_data_q;

  logic               accept;
  logic               cordic_done, div_done, div_start;
  logic signed [24:0] meas;
  logic [24:0]        gain;

  logic [32:0]        perr_sum, den;
  logic signed [47:0] pred_sum, est_sum;
  logic signed [38:0] gyro_rnd;
  logic signed [27:0] corr;
  logic signed [25:0] innov, est_mag;
  logic signed [9:0]  whole_n, thr_s;
  logic [56:0]        cov_rnd;
  logic [36:0]        recip_prod;
  logic [23:0]        back_prod;
  logic [6:0]         duty;
  logic [1:0]         dir_n;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign div_start     = (state_q == S_SUM);

  tkb_cordic u_cordic (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .accel_y_i (s_axis_tdata[15:0]),
    .accel_z_i (s_axis_tdata[31:16]),
    .done_o    (cordic_done),
    .angle_o   (meas)
  );

  tkb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (perr_q),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (gain)
  );

  always_comb begin
    perr_sum   = {1'b0, error_cov_q} + {9'd0, process_noise_q};
    den        = {1'b0, perr_q} + {9'd0, measure_noise_q};
    gyro_rnd   = 39'((gyro_q + 47'sd128) >>> 8);
    pred_sum   = 48'(angle_est_q) + 48'(gyro_rnd);
    innov      = 26'(meas) - 26'(pred_q);
    corr       = 28'((corr_prod_q + 52'sd8388608) >>> 24);
    est_sum    = 48'(pred_q) + 48'(corr);
    cov_rnd    = (cov_prod_q + 57'd8388608) >> 24;
    est_mag    = angle_est_q[24] ? -26'(angle_est_q) : 26'(angle_est_q);
    whole_n    = angle_est_q[24] ? -10'(est_mag[25:16]) : 10'(est_mag[25:16]);
    thr_s      = $signed({3'b000, tilt_threshold_q});
    if (whole_n < -thr_s) begin
      dir_n = DIR_BELOW;
      duty  = DUTY_BELOW;
    end else if (whole_n > thr_s) begin
      dir_n = DIR_ABOVE;
      duty  = DUTY_ABOVE;
    end else begin
      dir_n = DIR_BAND;
      duty  = DUTY_BAND;
    end
    recip_prod = prod_q * RECIP_1000;
    back_prod  = quot_q * THOUSAND;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      process_noise_q  <= PROCESS_NOISE_RST;
      measure_noise_q  <= MEASURE_NOISE_RST;
      step_time_q      <= STEP_TIME_RST;
      tilt_threshold_q <= TILT_THRESHOLD_RST;
      pwm_period_q     <= PWM_PERIOD_RST;
      angle_est_q      <= '0;
      error_cov_q      <= ERROR_COV_RST;
      m_valid_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROCESS_NOISE:  process_noise_q  <= cfg_wdata_i;
          REG_MEASURE_NOISE:  measure_noise_q  <= cfg_wdata_i;
          REG_STEP_TIME:      step_time_q      <= cfg_wdata_i;
          REG_TILT_THRESHOLD: tilt_threshold_q <= cfg_wdata_i[6:0];
          REG_PWM_PERIOD:     pwm_period_q     <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PRED;
          end
        end
        S_PRED:  state_q <= S_SUM;
        S_SUM:   state_q <= S_WAIT;
        S_WAIT: begin
          if (cordic_done && div_done) begin
            state_q <= S_MUL1;
          end
        end
        S_MUL1:  state_q <= S_MUL2;
        S_MUL2: begin
          angle_est_q <= sat25(est_sum);
          state_q     <= S_DIR;
        end
        S_DIR: begin
          error_cov_q <= cov_rnd[31:0];
          state_q     <= S_RECIP;
        end
        S_RECIP: state_q <= S_FIX;
        S_FIX:   state_q <= S_OUT;
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rate_q <= s_axis_tdata[53:32];
    end
    if (state_q == S_PRED) begin
      gyro_q <= 47'(rate_q) * 47'($signed({1'b0, step_time_q}));
      perr_q <= perr_sum[32] ? 32'hFFFF_FFFF : perr_sum[31:0];
    end
    if (state_q == S_SUM) begin
      pred_q <= sat25(pred_sum);
    end
    if (state_q == S_MUL1) begin
      corr_prod_q <= 52'(innov) * 52'($signed({1'b0, gain}));
    end
    if (state_q == S_MUL2) begin
      cov_prod_q <= 57'(25'h100_0000 - gain) * 57'(perr_q);
    end
    if (state_q == S_DIR) begin
      whole_q <= whole_n[8:0];
      dir_q   <= dir_n;
      prod_q  <= pwm_period_q * duty;
    end
    if (state_q == S_RECIP) begin
      quot_q <= recip_prod[36:23];
    end
    if (state_q == S_FIX) begin
      pulse_q <= (back_prod > {1'b0, prod_q}) ? 13'(quot_q - 14'd1) : quot_q[12:0];
    end
    if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {7'd0, pulse_q, dir_q, whole_q, angle_est_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
`default_nettype wire

>>> rtl/tkb_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt CORDIC
// Vectoring CORDIC giving -atan(y/z) in degrees, Q8.16, one step per cycle.
// ----------------------------------------------------------------------------
module tkb_cordic
  import tkb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  output logic                    done_o,
  output logic signed [24:0]      angle_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [4:0]         idx_q, idx_d;
  logic signed [39:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] acc_q, acc_d;
  logic signed [24:0] angle_q, angle_d;

  logic signed [16:0] z_abs, y_sgn;
  logic signed [39:0] dx, dy;
  logic signed [33:0] atan_s, acc_n, fin;

  always_comb begin
    z_abs  = accel_z_i[15] ? -{accel_z_i[15], accel_z_i} : {accel_z_i[15], accel_z_i};
    y_sgn  = accel_z_i[15] ? -{accel_y_i[15], accel_y_i} : {accel_y_i[15], accel_y_i};
    dx     = y_q >>> idx_q;
    dy     = x_q >>> idx_q;
    atan_s = $signed({2'b00, atan_deg(idx_q)});
    acc_n  = y_q[39] ? acc_q - atan_s : acc_q + atan_s;
    fin    = (-acc_n + 34'sd128) >>> 8;

    busy_d  = busy_q;
    done_d  = done_q;
    idx_d   = idx_q;
    x_d     = x_q;
    y_d     = y_q;
    acc_d   = acc_q;
    angle_d = angle_q;

    if (start_i) begin
      done_d = 1'b0;
      idx_d  = '0;
      acc_d  = '0;
      x_d    = 40'(z_abs) <<< 20;
      y_d    = 40'(y_sgn) <<< 20;
      if (accel_z_i == 16'sd0) begin
        done_d = 1'b1;
        busy_d = 1'b0;
        if (accel_y_i > 16'sd0) begin
          angle_d = -NINETY_Q16;
        end else if (accel_y_i < 16'sd0) begin
          angle_d = NINETY_Q16;
        end else begin
          angle_d = '0;
        end
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      acc_d = acc_n;
      if (y_q[39]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
      end
      idx_d = idx_q + 5'd1;
      if (idx_q == 5'(CORDIC_STEPS - 1)) begin
        busy_d  = 1'b0;
        done_d  = 1'b1;
        angle_d = fin[24:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    acc_q   <= acc_d;
    angle_q <= angle_d;
  end

  assign done_o  = done_q;
  assign angle_o = angle_q;

endmodule
`default_nettype wire

>>> rtl/tkb_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Kalman gain divider
// Restoring divider forming floor(P * 2^24 / D), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tkb_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [32:0] den_i,
  output logic             done_o,
  output logic [24:0]      quot_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [32:0] den_q, den_d;
  logic [24:0] quot_q, quot_d;

  logic        ge;
  logic [33:0] rem_n;

  always_comb begin
    ge    = rem_q >= {1'b0, den_q};
    rem_n = ge ? rem_q - {1'b0, den_q} : rem_q;

    busy_d = busy_q;
    done_d = done_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;

    if (start_i) begin
      rem_d  = {2'b00, num_i};
      den_d  = den_i;
      quot_d = '0;
      cnt_d  = 5'd24;
      if (den_i == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        done_d = 1'b0;
      end
    end else if (busy_q) begin
      quot_d = {quot_q[23:0], ge};
      rem_d  = {rem_n[32:0], 1'b0};
      cnt_d  = cnt_q - 5'd1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

>>> bench/tilt_kalman_bang_bang_drive_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt Kalman drive testbench
// Drives accelerometer and gyro words through the stream input and checks
// every result word against a bit-true model of the CORDIC tilt, the scalar
// Kalman step and the three-level PWM drive. Random idling on both sides, a
// long output hold-off and several register settings are covered.
// ----------------------------------------------------------------------------
module tilt_kalman_bang_bang_drive_test;
  import tkb_pkg::*;

  localparam longint CYCLE_LIMIT = 1000000;
  localparam int     SETTLE      = 40;

  typedef struct packed {
    logic signed [24:0] est;
    logic signed [8:0]  whole;
    dir_e               dir;
    logic [12:0]        pulse;
  } tilt_res_t;

  typedef struct {
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [21:0] g;
    bit                 typed;
    tilt_res_t          res;
  } stim_row_t;

  localparam longint ATAN_Q24 [0:31] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14,
    7, 4, 2, 1, 0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata = '0;
  logic        m_tready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_idx = '0;
  logic [23:0] cfg_wdata = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [55:0] m_tdata;

  tilt_kalman_bang_bang_drive DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  // Model copy of the registers and the filter state.
  longint          mdl_pnoise, mdl_mnoise, mdl_step, mdl_thr, mdl_period;
  longint          mdl_angle;
  longint unsigned mdl_cov;

  tilt_res_t expected_results[$];
  int        mismatches = 0;
  longint    cycles = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        hold_req = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  function automatic longint clamp_angle(input longint v);
    if (v > 16777215) return 16777215;
    if (v < -16777216) return -16777216;
    return v;
  endfunction

  function automatic tilt_res_t kalman_step(input logic signed [15:0] ay,
                                            input logic signed [15:0] az,
                                            input logic signed [21:0] rate);
    longint          vy, vz, xx, yy, acc, dx, dy, meas, pred, innov, corr, whole;
    longint unsigned perr, den, gain, pulse;
    tilt_res_t       r;
    vy = ay;
    vz = az;
    acc = 0;
    if (vz == 0) begin
      meas = (vy > 0) ? -5898240 : ((vy < 0) ? 5898240 : 0);
    end else begin
      if (vz < 0) begin
        vy = -vy;
        vz = -vz;
      end
      xx = vz * 1048576;
      yy = vy * 1048576;
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        dx = yy >>> i;
        dy = xx >>> i;
        if (yy >= 0) begin
          xx = xx + dx;
          yy = yy - dy;
          acc = acc + ATAN_Q24[i];
        end else begin
          xx = xx - dx;
          yy = yy + dy;
          acc = acc - ATAN_Q24[i];
        end
      end
      meas = (-acc + 128) >>> 8;
    end
    pred = clamp_angle(mdl_angle + ((longint'(rate) * mdl_step + 128) >>> 8));
    perr = mdl_cov + longint'(mdl_pnoise);
    if (perr > 64'hFFFF_FFFF) perr = 64'hFFFF_FFFF;
    den = perr + longint'(mdl_mnoise);
    gain = (den != 0) ? (perr << 24) / den : 0;
    innov = meas - pred;
    corr = (innov * longint'(gain) + (longint'(1) << 23)) >>> 24;
    mdl_angle = clamp_angle(pred + corr);
    mdl_cov = (((64'd16777216 - gain) * perr + 64'd8388608) >> 24) & 64'hFFFF_FFFF;
    whole = (mdl_angle >= 0) ? (mdl_angle >>> 16) : -((-mdl_angle) >>> 16);
    if (whole < -mdl_thr) begin
      r.dir = DIR_BELOW;
      pulse = mdl_period * 115 / 1000;
    end else if (whole > mdl_thr) begin
      r.dir = DIR_ABOVE;
      pulse = mdl_period * 35 / 1000;
    end else begin
      r.dir = DIR_BAND;
      pulse = mdl_period * 75 / 1000;
    end
    r.est = mdl_angle[24:0];
    r.whole = whole[8:0];
    r.pulse = pulse[12:0];
    return r;
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_PROCESS_NOISE:  mdl_pnoise = val;
      REG_MEASURE_NOISE:  mdl_mnoise = val;
      REG_STEP_TIME:      mdl_step = val;
      REG_TILT_THRESHOLD: mdl_thr = val[6:0];
      REG_PWM_PERIOD:     mdl_period = val[15:0];
      default: ;
    endcase
  endtask

  task automatic send_word(input logic signed [15:0] ay, input logic signed [15:0] az,
                           input logic signed [21:0] rate, input bit typed,
                           input tilt_res_t typed_res);
    tilt_res_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, rate, az, ay};
    do @(posedge clk_i); while (!s_tready);
    r = kalman_step(ay, az, rate);
    expected_results.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic send_random(input int count);
    logic signed [15:0] ay, az;
    logic signed [21:0] rate;
    tilt_res_t          none;
    none = '0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) == 0) begin
        ay = 16'($urandom);
        az = 16'($urandom);
        rate = 22'($urandom);
      end else begin
        ay = 16'($urandom_range(8000) - 4000);
        az = ($urandom_range(9) == 0) ? 16'sd0 : 16'($urandom_range(32000) - 16000);
        rate = 22'($urandom_range(20000) - 10000);
      end
      send_word(ay, az, rate, 1'b0, none);
      if (n == count / 2 && tx_idle_pct == 7) hold_req <= hold_req + 1;
    end
  endtask

  task automatic random_config();
    write_reg(REG_PROCESS_NOISE, ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(200000)));
    write_reg(REG_MEASURE_NOISE, ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(200000)));
    write_reg(REG_STEP_TIME, ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(300000)));
    write_reg(REG_TILT_THRESHOLD, 24'($urandom_range(127)));
    write_reg(REG_PWM_PERIOD, 24'($urandom_range(65535)));
  endtask

  stim_row_t rows [$];

  function automatic stim_row_t row(input int ay, input int az, input int rate);
    stim_row_t s;
    s.y = 16'(ay);
    s.z = 16'(az);
    s.g = 22'(rate);
    s.typed = 1'b0;
    s.res = '0;
    return s;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** tilt_kalman_bang_bang_drive: FAILED **");
      $finish;
    end
  end

  // Output side: random stalls plus a long hold-off on each request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    tilt_res_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[24:0], m_tdata[33:25], dir_e'(m_tdata[35:34]), m_tdata[48:36]};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.est !== want.est || got.whole !== want.whole || got.dir !== want.dir ||
            got.pulse !== want.pulse) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected est %0d whole %0d dir %0d pulse %0d, got %0d %0d %0d %0d",
                     want.est, want.whole, want.dir, want.pulse,
                     got.est, got.whole, got.dir, got.pulse);
        end
      end
    end
  end

  initial begin
    stim_row_t s;
    mdl_pnoise = PROCESS_NOISE_RST;
    mdl_mnoise = MEASURE_NOISE_RST;
    mdl_step = STEP_TIME_RST;
    mdl_thr = TILT_THRESHOLD_RST;
    mdl_period = PWM_PERIOD_RST;
    mdl_angle = 0;
    mdl_cov = ERROR_COV_RST;

    // Level input from reset: estimate stays zero, in band, 7.5 percent of 20000.
    s = row(0, 0, 0);
    s.typed = 1'b1;
    s.res = {25'sd0, 9'sd0, DIR_BAND, 13'd1500};
    rows.push_back(s);
    rows.push_back(row(1, 0, 0));
    rows.push_back(row(-1, 0, 0));
    rows.push_back(row(32767, 32767, 0));
    rows.push_back(row(-32768, -32768, 0));
    rows.push_back(row(32767, -32768, 0));
    rows.push_back(row(-32768, 1, 0));
    rows.push_back(row(100, -5, 1000));
    rows.push_back(row(0, 32767, 2097151));
    rows.push_back(row(0, 32767, 2097151));
    rows.push_back(row(0, 32767, -2097152));
    rows.push_back(row(0, -32768, -2097152));
    rows.push_back(row(0, 1, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_word(rows[i].y, rows[i].z, rows[i].g, rows[i].typed, rows[i].res);
    wait_idle();

    // Zero variances drive the gain to zero once the error has collapsed.
    write_reg(REG_PROCESS_NOISE, 24'd0);
    write_reg(REG_MEASURE_NOISE, 24'd0);
    write_reg(REG_STEP_TIME, 24'hFFFFFF);
    write_reg(REG_TILT_THRESHOLD, 24'd0);
    write_reg(REG_PWM_PERIOD, 24'd0);
    send_word(300, 1000, 5, 1'b0, '0);
    send_word(-300, 1000, -5, 1'b0, '0);
    send_word(0, 0, 2097151, 1'b0, '0);
    send_word(0, 0, -2097152, 1'b0, '0);
    send_word(-5, 1000, 0, 1'b0, '0);
    wait_idle();

    write_reg(REG_PROCESS_NOISE, 24'hFFFFFF);
    write_reg(REG_MEASURE_NOISE, 24'hFFFFFF);
    write_reg(REG_STEP_TIME, 24'd0);
    write_reg(REG_TILT_THRESHOLD, 24'd90);
    write_reg(REG_PWM_PERIOD, 24'd65535);
    send_word(32767, 1, 0, 1'b0, '0);
    send_word(-32768, 1, 0, 1'b0, '0);
    send_word(1, 32767, 12345, 1'b0, '0);
    wait_idle();

    write_reg(REG_TILT_THRESHOLD, 24'd2);
    write_reg(REG_PWM_PERIOD, 24'd1);
    write_reg(REG_STEP_TIME, 24'd64525);
    write_reg(REG_PROCESS_NOISE, 24'd58982);
    write_reg(REG_MEASURE_NOISE, 24'd655);

    tx_idle_pct = 7;
    rx_idle_pct = 70;
    for (int p = 0; p < 3; p++) begin
      send_random(200);
      wait_idle();
      random_config();
    end
    tx_idle_pct = 70;
    rx_idle_pct = 7;
    for (int p = 0; p < 3; p++) begin
      send_random(200);
      wait_idle();
      random_config();
    end
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int p = 0; p < 3; p++) begin
      send_random(185);
      wait_idle();
      if (p < 2) random_config();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** tilt_kalman_bang_bang_drive: PASSED **");
    end else begin
      $display("** tilt_kalman_bang_bang_drive: FAILED **");
    end
    $finish;
  end

endmodule
